// File: rtl/core/psm_pkg.sv
package psm_pkg;

  // command codes carried in tuser
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_PLAY  = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_BIND  = 3'd4;

  localparam int CMD_W      = 3;
  localparam int VIDX_W     = 3;
  localparam int GAIN_W     = 16;
  localparam int ADDR_W     = 16;
  localparam int SMP_W      = 16;
  localparam int POS_W      = 17;
  localparam int SUM_W      = 18;   // base plus position before wrap
  localparam int PROD_W     = 33;   // signed sample times unsigned gain
  localparam int TERM_W     = 18;   // one voice contribution after the q15 shift
  localparam int MIX_W      = 19;
  localparam int ACT_W      = 4;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  localparam logic [MIX_W-1:0] MIX_POS_LIMIT = 19'h3FFFF;
  localparam logic [MIX_W-1:0] MIX_NEG_LIMIT = 19'h40000;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

// File: rtl/core/psm_addr_mod.sv
module psm_addr_mod #(
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [psm_pkg::SUM_W-1:0]       x_in,
  output psm_pkg::mod_stat_t              stat,
  output logic [$clog2(SAMPLE_DEPTH)-1:0] addr_out
);
  import psm_pkg::*;

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int XW = SUM_W;
  localparam int SH = XW + AW;
  localparam int RW = XW + 2;
  localparam int QW = (XW + 1 > AW) ? XW + 1 - AW : 1;
  localparam int PW = (XW + RW > SH + QW) ? XW + RW : SH + QW;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(SAMPLE_DEPTH) - 1)
                             / longint'(SAMPLE_DEPTH);
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

  logic [XW-1:0] x_r;
  logic [QW-1:0] q_r;
  logic [XW-1:0] rem_r;
  logic [1:0]    step_r;
  logic          done_r;
  logic [PW-1:0] prod;

  // quotient from a rounded-up reciprocal, exact for every x below 2**XW,
  // then the remainder by one multiply and subtract
  assign prod = PW'(x_r) * PW'(RECIP_V);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= {step_r[0], start};
      done_r <= step_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_in;
    end
    if (step_r[0]) begin
      q_r <= prod[SH +: QW];
    end
    if (step_r[1]) begin
      rem_r <= x_r - XW'(q_r) * XW'(SAMPLE_DEPTH);
    end
  end

  assign stat.busy = |step_r;
  assign stat.done = done_r;
  assign addr_out  = AW'(rem_r);

endmodule

// File: rtl/core/polyphonic_sample_mixer.sv
// channel | dir | beat fields (low bit up)
// --------+-----+--------------------------------------------------------------
// in_     | in  | tuser: cmd[2:0]
//         |     | tdata: voice_index, volume, loop_enable, address,
//         |     |        sample_value, region_length, zero pad
// out_    | out | tdata: mix_sample, active_voices, zero pad
//
// one voice per step through the sample memory and the multiplier; a tick visits
// every voice in turn, and a voice that reads a sample waits on the address wrap
// unit, then reads memory, multiplies and accumulates
// a sample write waits on the address wrap unit; play, stop and bind act from idle
// in_tready is high only while idle; a tick result waits in the output register
// and the next command is taken while it is stalled there
// synchronous active-low reset clears all voice state; sample memory is not cleared
module polyphonic_sample_mixer #(
  parameter int VOICES       = 8,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // voice_index[2:0] volume[18:3] loop_enable[19] address[35:20]
  // sample_value[51:36] region_length[68:52]
  input  logic [psm_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd[2:0]
  input  logic [psm_pkg::CMD_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // mix_sample[18:0] active_voices[22:19]
  output logic [psm_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import psm_pkg::*;

  localparam int AW    = $clog2(SAMPLE_DEPTH);
  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW    = $clog2(VOICES + 1);
  localparam int ACC_W = TERM_W + VW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_VSEL = 4'd1;
  localparam logic [3:0] S_TMOD = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_DONE = 4'd6;
  localparam logic [3:0] S_WMOD = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(262143);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-262144);

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // voice state
  logic              bound_r [VOICES];
  logic [ADDR_W-1:0] base_r  [VOICES];
  logic [POS_W-1:0]  len_r   [VOICES];
  logic              play_r  [VOICES];
  logic [POS_W-1:0]  pos_r   [VOICES];
  logic [GAIN_W-1:0] gain_r  [VOICES];
  logic              loop_r  [VOICES];

  logic [SMP_W-1:0]  mem [SAMPLE_DEPTH];
  logic [SMP_W-1:0]  rd_data_r;
  logic [SMP_W-1:0]  wdata_r;

  logic [VW-1:0]            k_r;
  logic [CW-1:0]            cnt_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     out_valid_r;
  logic [MIX_W-1:0]         out_mix_r;
  logic [ACT_W-1:0]         out_act_r;

  logic [CMD_W-1:0]  in_cmd;
  logic [VIDX_W-1:0] in_vidx;
  logic [GAIN_W-1:0] in_vol;
  logic              in_loop;
  logic [ADDR_W-1:0] in_addr;
  logic [SMP_W-1:0]  in_smp;
  logic [POS_W-1:0]  in_len;
  logic              in_fire;
  logic              voice_ok;
  logic [VW-1:0]     vsel;

  logic              cur_play;
  logic              cur_loop;
  logic [POS_W-1:0]  cur_pos;
  logic [POS_W-1:0]  cur_len;
  logic [ADDR_W-1:0] cur_base;
  logic [GAIN_W-1:0] cur_gain;
  logic              cur_live;
  logic              last_k;

  logic              mod_start;
  logic [SUM_W-1:0]  mod_x;
  mod_stat_t         mod_stat;
  logic [AW-1:0]     maddr;

  logic signed [TERM_W-1:0] term;
  logic [MIX_W-1:0]         mix_sat;
  logic                     out_free;

  assign in_cmd  = in_tuser;
  assign in_vidx = in_tdata[2:0];
  assign in_vol  = in_tdata[18:3];
  assign in_loop = in_tdata[19];
  assign in_addr = in_tdata[35:20];
  assign in_smp  = in_tdata[51:36];
  assign in_len  = in_tdata[68:52];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign voice_ok  = (int'(in_vidx) < VOICES);
  assign vsel      = VW'(in_vidx);

  assign cur_play = play_r[k_r];
  assign cur_loop = loop_r[k_r];
  assign cur_pos  = pos_r[k_r];
  assign cur_len  = len_r[k_r];
  assign cur_base = base_r[k_r];
  assign cur_gain = gain_r[k_r];
  assign cur_live = cur_play && (cur_pos < cur_len);
  assign last_k   = (k_r == VW'(VOICES - 1));

  assign mod_start = (in_fire && (in_cmd == CMD_WRITE)) || ((state_r == S_VSEL) && cur_live);
  assign mod_x     = (state_r == S_VSEL) ? (SUM_W'(cur_base) + SUM_W'(cur_pos))
                                         : SUM_W'(in_addr);

  psm_addr_mod #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_addr_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .x_in     (mod_x),
    .stat     (mod_stat),
    .addr_out (maddr)
  );

  // floor of the q15 product
  assign term = prod_r[PROD_W-1:15];

  assign mix_sat  = (acc_r > ACC_MAX) ? MIX_POS_LIMIT :
                    (acc_r < ACC_MIN) ? MIX_NEG_LIMIT : acc_r[MIX_W-1:0];
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_TICK:  state_nxt = S_VSEL;
            CMD_WRITE: state_nxt = S_WMOD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_VSEL: begin
        if (cur_live) begin
          state_nxt = S_TMOD;
        end else if (last_k) begin
          state_nxt = S_DONE;
        end
      end
      S_TMOD: begin
        if (mod_stat.done) begin
          state_nxt = S_RD;
        end
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_ACC;
      S_ACC: state_nxt = last_k ? S_DONE : S_VSEL;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_WMOD: begin
        if (mod_stat.done) begin
          state_nxt = S_WR;
        end
      end
      S_WR:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      cnt_r       <= '0;
      acc_r       <= '0;
      for (int i = 0; i < VOICES; i++) begin
        bound_r[i] <= 1'b0;
        base_r[i]  <= '0;
        len_r[i]   <= '0;
        play_r[i]  <= 1'b0;
        pos_r[i]   <= '0;
        gain_r[i]  <= '0;
        loop_r[i]  <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;

      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_cmd)
              CMD_TICK: begin
                k_r   <= '0;
                cnt_r <= '0;
                acc_r <= '0;
              end
              CMD_PLAY: begin
                if (voice_ok && bound_r[vsel]) begin
                  play_r[vsel] <= 1'b1;
                  pos_r[vsel]  <= '0;
                  gain_r[vsel] <= in_vol;
                  loop_r[vsel] <= in_loop;
                end
              end
              CMD_STOP: begin
                if (voice_ok) begin
                  play_r[vsel] <= 1'b0;
                end
              end
              CMD_BIND: begin
                if (voice_ok) begin
                  bound_r[vsel] <= 1'b1;
                  base_r[vsel]  <= in_addr;
                  len_r[vsel]   <= in_len;
                end
              end
              default: ;
            endcase
          end
        end
        S_VSEL: begin
          if (!cur_live) begin
            // voice not playing or at end of region: rewind or stop a playing one, nothing added
            if (cur_play) begin
              if (cur_loop) begin
                pos_r[k_r] <= '0;
                cnt_r      <= cnt_r + 1'b1;
              end else begin
                play_r[k_r] <= 1'b0;
              end
            end
            if (!last_k) begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        S_ACC: begin
          acc_r      <= acc_r + ACC_W'(term);
          pos_r[k_r] <= cur_pos + 1'b1;
          cnt_r      <= cnt_r + 1'b1;
          if (!last_k) begin
            k_r <= k_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == CMD_WRITE)) begin
      wdata_r <= in_smp;
    end
    if (state_r == S_MUL) begin
      prod_r <= $signed(rd_data_r) * $signed({1'b0, cur_gain});
    end
    if ((state_r == S_DONE) && out_free) begin
      out_mix_r <= mix_sat;
      out_act_r <= (int'(cnt_r) > 15) ? 4'd15 : ACT_W'(cnt_r);
    end
  end

  // sample memory, one port
  always_ff @(posedge clk) begin
    if (state_r == S_WR) begin
      mem[maddr] <= wdata_r;
    end
    if (state_r == S_RD) begin
      rd_data_r <= mem[maddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_act_r, out_mix_r};

endmodule
